>>> src/bda_pkg.sv
`timescale 1ns / 1ps

package bda_pkg;

   localparam int IN_WIDTH   = 32;
   localparam int MAX_DIGITS = 10;
   localparam int DIGIT_BITS = 4;
   localparam int BCD_BITS   = MAX_DIGITS * DIGIT_BITS;
   localparam int IDX_BITS   = $clog2(MAX_DIGITS);
   localparam int CHAR_BITS  = 6;

   localparam logic [CHAR_BITS-1:0]  ASCII_ZERO = 6'd48;
   localparam logic [DIGIT_BITS-1:0] DD_LIMIT   = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DD_ADJUST  = 4'd3;

   typedef logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] bcd_type;
   typedef logic [IDX_BITS-1:0]                   idx_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_FIND    = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic find;
      logic next;
   } cmd_type;

   typedef struct packed {
      logic shift_last;
      logic digit_last;
   } status_type;

endpackage

>>> src/bda_datapath.sv
`timescale 1ns / 1ps

module bda_datapath #(
   parameter int EFF_BITS = 32
) (
   input  logic                           clock,
   input  logic [bda_pkg::IN_WIDTH-1:0]   number,
   input  bda_pkg::cmd_type               cmd,
   output bda_pkg::status_type            status,
   output logic [bda_pkg::CHAR_BITS-1:0]  digit_char
);
   import bda_pkg::*;

   localparam int CntBits = $clog2(EFF_BITS);

   logic [EFF_BITS-1:0] bin_ff, bin_in;
   bcd_type             bcd_ff, bcd_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   idx_type             idx_ff, idx_in;

   bcd_type             bcd_adj;
   logic [BCD_BITS-1:0] adj_flat;
   idx_type             top_idx;

   // add-3 correction on every digit of 5 or more ahead of the shift
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i] >= DD_LIMIT) begin
            bcd_adj[i] = bcd_ff[i] + DD_ADJUST;
         end else begin
            bcd_adj[i] = bcd_ff[i];
         end
      end
      adj_flat = bcd_adj;
   end

   // highest nonzero digit, zero if the value is zero
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i] != '0) begin
            top_idx = IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         bin_in = number[EFF_BITS-1:0];
         bcd_in = '0;
         cnt_in = '0;
      end else if (cmd.shift) begin
         bcd_in = {adj_flat[BCD_BITS-2:0], bin_ff[EFF_BITS-1]};
         bin_in = {bin_ff[EFF_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.find) begin
         idx_in = top_idx;
      end else if (cmd.next) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
   end

   assign status.shift_last = (cnt_ff == CntBits'(EFF_BITS - 1));
   assign status.digit_last = (idx_ff == '0);
   assign digit_char        = ASCII_ZERO + CHAR_BITS'(bcd_ff[idx_ff]);

endmodule

>>> src/bda_controller.sv
`timescale 1ns / 1ps

module bda_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bda_pkg::status_type  status,
   output bda_pkg::cmd_type     cmd
);
   import bda_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (status.shift_last) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.digit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// Binary to decimal ASCII converter.
// Request channel (req_valid / req_stall / req_number) takes one unsigned
// value per transaction; only its low min(VALUE_BITS, 32) bits are used.
// Response channel (rsp_valid / rsp_stall / rsp_digit_char / rsp_last_digit)
// returns the decimal text one ASCII digit per transaction, most significant
// first, leading zeros dropped; zero gives the single digit '0'.
// rsp_last_digit marks the least significant digit of the number.
// Conversion (double dabble): W = min(VALUE_BITS, 32) shift-add-3 steps,
// one bit per cycle, then a step that locates the leading digit; the
// first digit is valid once that step is done.
// A number gives 1 to 10 digits. The next request is taken the cycle
// after the last digit leaves, so no new number is accepted while one
// is still in conversion or its digits are being emitted.
// req_stall is high from a request until its last digit is delivered.
// Receiver stall holds the current digit and its flag unchanged.
// Reset (synchronous) returns the controller to idle; any number in flight
// is dropped.

module binary_to_decimal_ascii_top #(
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bda_pkg::IN_WIDTH-1:0]   req_number,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bda_pkg::CHAR_BITS-1:0]  rsp_digit_char,
   output logic                           rsp_last_digit
);
   import bda_pkg::*;

   // value bits above the input field width never reach the converter
   localparam int EffBits = (VALUE_BITS < IN_WIDTH) ? VALUE_BITS : IN_WIDTH;

   cmd_type    cmd;
   status_type status;

   bda_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bda_datapath #(
      .EFF_BITS (EffBits)
   ) u_dp (
      .clock      (clock),
      .number     (req_number),
      .cmd        (cmd),
      .status     (status),
      .digit_char (rsp_digit_char)
   );

   // index reaches zero exactly on the least significant digit
   assign rsp_last_digit = status.digit_last;

endmodule

>>> src/bda_checker.sv
`timescale 1ns / 1ps

module bda_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [bda_pkg::CHAR_BITS-1:0]  rsp_digit_char,
   input  logic                           rsp_last_digit
);

   // stalled digit holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_char)
                                 && $stable(rsp_last_digit))
      else $error("stalled response changed");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= 6'd48) && (rsp_digit_char <= 6'd57))
      else $error("response is not a decimal digit");

   // no new request while a number is being emitted
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while digits pending");

   // digits of one number follow without a gap
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_digit |=> rsp_valid)
      else $error("gap inside a number");

   // conversion takes time before the first digit
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid && req_stall)
      else $error("digit appeared right after request");

endmodule

bind binary_to_decimal_ascii_top bda_checker u_bda_checker (.*);
